FILE: src/clas_pkg.sv
// ----------------------------------------------------------------------------
// clas_pkg: shared types and constants of the argument splitter
// Result word layout, per-character result bundle and the character codes.
// ----------------------------------------------------------------------------
package clas_pkg;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_EOL    = 8'h00;

  localparam int QDEPTH   = 4;
  localparam int Q_AW     = 2;
  localparam int Q_CW     = 3;
  localparam int OUT_DW   = 40;

  typedef enum logic [1:0] {
    K_BYTE     = 2'd0,
    K_ARG_END  = 2'd1,
    K_LINE_END = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  byte_v;
    logic [5:0]  rep;
    logic [7:0]  cnt;
    logic [11:0] len;
    logic        ovf;
  } res_t;

  typedef struct packed {
    logic [1:0]      n;
    res_t [2:0]      r;
  } bundle_t;

  typedef struct packed {
    logic    push;
    bundle_t bundle;
  } q_wr_t;

endpackage

FILE: src/command_line_argument_splitter.sv
// ----------------------------------------------------------------------------
// command_line_argument_splitter: command-line byte stream to argument words
// Splits a zero-terminated command line into argument bytes, backslash runs,
// argument ends and an end-of-line summary with count and length.
//
// The input channel takes one character per word; a zero character ends the
// line. The output channel gives one result per word: tuser holds the kind
// (byte run, end of argument, end of line), tdata the byte, repeat count,
// argument count, total length and sticky overflow flag, and tlast marks the
// final result caused by one character. A character may cause no result.
// A character is registered at acceptance and its results are written into a
// four-entry bundle queue at the next edge, and the first result is presented
// as soon as its bundle is in the queue. One character is accepted every
// cycle while the queue has room; sustained output is one result per cycle
// while the receiver is ready, so a character that causes two or three results
// is handed out as that many result words, one at a time.
// When the receiver stalls, bundles collect in the queue and in_tready drops
// once the queue and the character register together would fill it.
// A synchronous reset clears the line state and empties the queue; after each
// end of line the state returns to its reset value for the next line.
// ----------------------------------------------------------------------------
module command_line_argument_splitter #(
  parameter int MAX_RUN    = 63,
  parameter int MAX_ARGS   = 255,
  parameter int MAX_LENGTH = 4095
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] ch
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [7:0] out_byte, [13:8] repeat_res, [21:14] arg_count,
  // [33:22] total_length, [34] overflow
  output logic [clas_pkg::OUT_DW-1:0] out_tdata,
  output logic [1:0]                  out_tuser,  // [1:0] kind
  output logic                        out_tlast
);
  import clas_pkg::*;

  logic            busy;
  logic            in_take;
  q_wr_t           wr;
  logic [Q_CW-1:0] q_count;

  assign in_tready = ({1'b0, q_count} + {{Q_CW{1'b0}}, busy}) < (Q_CW + 1)'(QDEPTH);
  assign in_take   = in_tvalid && in_tready;

  clas_parse #(
    .MAX_RUN    (MAX_RUN),
    .MAX_ARGS   (MAX_ARGS),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_take (in_take),
    .in_ch   (in_tdata),
    .busy    (busy),
    .wr      (wr)
  );

  clas_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .count      (q_count),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef NO_ASSERTIONS
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (Q_CW + 1)'(q_count) <= (Q_CW + 1)'(QDEPTH))
    else $error("bundle queue count beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr.push |-> ((Q_CW + 1)'(q_count) < (Q_CW + 1)'(QDEPTH)))
    else $error("bundle pushed into a full queue");

  a_eol_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == K_LINE_END)) |-> out_tlast)
    else $error("end of line is not the final result of its character");

  a_rep_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser == K_BYTE) == (out_tdata[13:8] != 6'd0)))
    else $error("repeat count does not match result kind");
`endif

endmodule

FILE: src/clas_parse.sv
// ----------------------------------------------------------------------------
// clas_parse: character register and parsing step
// Holds the line state and turns one registered character into a result bundle.
// ----------------------------------------------------------------------------
module clas_parse #(
  parameter int MAX_RUN    = 63,
  parameter int MAX_ARGS   = 255,
  parameter int MAX_LENGTH = 4095
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_take,
  input  logic [7:0]     in_ch,
  output logic           busy,
  output clas_pkg::q_wr_t wr
);
  import clas_pkg::*;

  localparam int RUN_CAP_I = (MAX_RUN < 63) ? MAX_RUN : 63;
  localparam int ARGS_CAP_I = (MAX_ARGS < 255) ? MAX_ARGS : 255;
  localparam int LEN_CAP_I = (MAX_LENGTH < 4095) ? MAX_LENGTH : 4095;
  localparam logic [5:0]  RUN_CAP  = RUN_CAP_I[5:0];
  localparam logic [7:0]  ARGS_CAP = ARGS_CAP_I[7:0];
  localparam logic [11:0] LEN_CAP  = LEN_CAP_I[11:0];

  logic        vld_r;
  logic [7:0]  ch_r;
  logic        ia_r, ia_nxt;
  logic        iq_r, iq_nxt;
  logic        qp_r, qp_nxt;
  logic [5:0]  run_r, run_nxt;
  logic [7:0]  args_r, args_nxt;
  logic [11:0] len_r, len_nxt;
  logic        ovf_r, ovf_nxt;
  logic        ws;
  logic [5:0]  half;
  logic [1:0]  n_res;
  res_t [2:0]  res;
  logic [12:0] sum;

  function automatic logic [12:0] add_len(logic [11:0] len, logic [5:0] n, logic ovf);
    logic [12:0] r;
    if ((LEN_CAP - len) < {6'd0, n}) begin
      r = {1'b1, LEN_CAP};
    end else begin
      r = {ovf, len + {6'd0, n}};
    end
    return r;
  endfunction

  function automatic res_t mk(kind_e k, logic [7:0] b, logic [5:0] rp,
                              logic [7:0] c, logic [11:0] l, logic o);
    res_t r;
    r.kind   = k;
    r.byte_v = b;
    r.rep    = rp;
    r.cnt    = c;
    r.len    = l;
    r.ovf    = o;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_take;
    end
    if (in_take) begin
      ch_r <= in_ch;
    end
  end

  always_comb begin
    ia_nxt   = ia_r;
    iq_nxt   = iq_r;
    qp_nxt   = qp_r;
    run_nxt  = run_r;
    args_nxt = args_r;
    len_nxt  = len_r;
    ovf_nxt  = ovf_r;
    n_res    = 2'd0;
    res      = '0;
    sum      = '0;
    ws       = (ch_r == CH_SPACE) || (ch_r == CH_TAB);
    half     = run_r >> 1;
    if (vld_r) begin
      if (ch_r == CH_EOL) begin
        if (ia_r) begin
          if (run_r != 6'd0) begin
            sum = add_len(len_nxt, run_r, ovf_nxt);
            {ovf_nxt, len_nxt} = sum;
            res[n_res] = mk(K_BYTE, CH_BSLASH, run_r, 8'd0, 12'd0, ovf_nxt);
            n_res = n_res + 2'd1;
          end
          sum = add_len(len_nxt, 6'd1, ovf_nxt);
          {ovf_nxt, len_nxt} = sum;
          res[n_res] = mk(K_ARG_END, 8'd0, 6'd0, 8'd0, 12'd0, ovf_nxt);
          n_res = n_res + 2'd1;
        end
        res[n_res] = mk(K_LINE_END, 8'd0, 6'd0, args_nxt, len_nxt, ovf_nxt);
        n_res = n_res + 2'd1;
        ia_nxt   = 1'b0;
        iq_nxt   = 1'b0;
        qp_nxt   = 1'b0;
        run_nxt  = 6'd0;
        args_nxt = 8'd0;
        len_nxt  = 12'd0;
        ovf_nxt  = 1'b0;
      end else if (qp_r && (ch_r == CH_QUOTE)) begin
        qp_nxt = 1'b0;
        sum = add_len(len_nxt, 6'd1, ovf_nxt);
        {ovf_nxt, len_nxt} = sum;
        res[n_res] = mk(K_BYTE, CH_QUOTE, 6'd1, 8'd0, 12'd0, ovf_nxt);
        n_res = n_res + 2'd1;
      end else begin
        qp_nxt = 1'b0;
        if (ia_r || !ws) begin
          if (!ia_r) begin
            ia_nxt = 1'b1;
            if (args_r >= ARGS_CAP) begin
              args_nxt = ARGS_CAP;
              ovf_nxt  = 1'b1;
            end else begin
              args_nxt = args_r + 8'd1;
            end
          end
          if (ch_r == CH_BSLASH) begin
            if (run_r >= RUN_CAP) begin
              run_nxt = RUN_CAP;
              ovf_nxt = 1'b1;
            end else begin
              run_nxt = run_r + 6'd1;
            end
          end else if (ch_r == CH_QUOTE) begin
            run_nxt = 6'd0;
            if (half != 6'd0) begin
              sum = add_len(len_nxt, half, ovf_nxt);
              {ovf_nxt, len_nxt} = sum;
              res[n_res] = mk(K_BYTE, CH_BSLASH, half, 8'd0, 12'd0, ovf_nxt);
              n_res = n_res + 2'd1;
            end
            if (!run_r[0]) begin
              if (iq_r) begin
                iq_nxt = 1'b0;
                qp_nxt = 1'b1;
              end else begin
                iq_nxt = 1'b1;
              end
            end else begin
              sum = add_len(len_nxt, 6'd1, ovf_nxt);
              {ovf_nxt, len_nxt} = sum;
              res[n_res] = mk(K_BYTE, CH_QUOTE, 6'd1, 8'd0, 12'd0, ovf_nxt);
              n_res = n_res + 2'd1;
            end
          end else begin
            run_nxt = 6'd0;
            if (run_r != 6'd0) begin
              sum = add_len(len_nxt, run_r, ovf_nxt);
              {ovf_nxt, len_nxt} = sum;
              res[n_res] = mk(K_BYTE, CH_BSLASH, run_r, 8'd0, 12'd0, ovf_nxt);
              n_res = n_res + 2'd1;
            end
            sum = add_len(len_nxt, 6'd1, ovf_nxt);
            {ovf_nxt, len_nxt} = sum;
            if (ws && !iq_r) begin
              res[n_res] = mk(K_ARG_END, 8'd0, 6'd0, 8'd0, 12'd0, ovf_nxt);
              ia_nxt = 1'b0;
            end else begin
              res[n_res] = mk(K_BYTE, ch_r, 6'd1, 8'd0, 12'd0, ovf_nxt);
            end
            n_res = n_res + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ia_r   <= 1'b0;
      iq_r   <= 1'b0;
      qp_r   <= 1'b0;
      run_r  <= 6'd0;
      args_r <= 8'd0;
      len_r  <= 12'd0;
      ovf_r  <= 1'b0;
    end else begin
      ia_r   <= ia_nxt;
      iq_r   <= iq_nxt;
      qp_r   <= qp_nxt;
      run_r  <= run_nxt;
      args_r <= args_nxt;
      len_r  <= len_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  assign busy        = vld_r;
  assign wr.push     = vld_r && (n_res != 2'd0);
  assign wr.bundle.n = n_res;
  assign wr.bundle.r = res;

endmodule

FILE: src/clas_outq.sv
// ----------------------------------------------------------------------------
// clas_outq: result bundle queue and serializer
// Buffers per-character bundles and hands their results out one word at a time.
// ----------------------------------------------------------------------------
module clas_outq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  clas_pkg::q_wr_t             wr,
  output logic [clas_pkg::Q_CW-1:0]   count,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [clas_pkg::OUT_DW-1:0] out_tdata,
  output logic [1:0]                  out_tuser,
  output logic                        out_tlast
);
  import clas_pkg::*;

  bundle_t         mem [QDEPTH];
  logic [Q_AW-1:0] wp_r, rp_r;
  logic [Q_CW-1:0] cnt_r;
  logic [1:0]      idx_r;
  bundle_t         head;
  res_t            cur;
  logic            is_last;
  logic            pop;

  assign head    = mem[rp_r];
  assign cur     = head.r[idx_r];
  assign is_last = (idx_r == (head.n - 2'd1));
  assign pop     = out_tvalid && out_tready && is_last;

  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem[wp_r] <= wr.bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
      idx_r <= 2'd0;
    end else begin
      if (wr.push) begin
        wp_r <= wp_r + Q_AW'(1);
      end
      if (pop) begin
        rp_r  <= rp_r + Q_AW'(1);
        idx_r <= 2'd0;
      end else if (out_tvalid && out_tready) begin
        idx_r <= idx_r + 2'd1;
      end
      cnt_r <= cnt_r + Q_CW'(wr.push) - Q_CW'(pop);
    end
  end

  assign count      = cnt_r;
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {5'd0, cur.ovf, cur.len, cur.cnt, cur.rep, cur.byte_v};
  assign out_tuser  = cur.kind;
  assign out_tlast  = is_last;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the command-line argument splitter
// Feeds zero-terminated command lines one character per word, works out the
// expected result words with a parsing model of its own and checks every
// output word field by field. The tests cover the quoting and backslash
// rules, saturation of the run, count and length, and long output stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import clas_pkg::*;

  localparam int RUN_CAP  = 63;
  localparam int ARGS_CAP = 255;
  localparam int LEN_CAP  = 4095;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  byte_v;
    logic [5:0]  rep;
    logic [7:0]  cnt;
    logic [11:0] len;
    logic        ovf;
    logic        last;
  } split_word_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic [7:0]        in_tdata   = 8'h00;
  logic              out_tready = 1'b0;
  logic              in_tready;
  logic              out_tvalid;
  logic [OUT_DW-1:0] out_tdata;
  logic [1:0]        out_tuser;
  logic              out_tlast;

  split_word_t expected_words[$];
  split_word_t char_words[$];

  // Line state of the parsing model.
  bit in_arg;
  bit quoted;
  bit quote_hold;
  int slash_run;
  int arg_total;
  int line_len;
  bit ovf_flag;

  int err_count;
  int chars_sent;
  bit idle_on = 1'b1;
  int hold_cycles;

  command_line_argument_splitter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("command_line_argument_splitter test failed");
    $finish;
  end

  function automatic void add_len(int n);
    if (LEN_CAP - line_len < n) begin
      line_len = LEN_CAP;
      ovf_flag = 1'b1;
    end else begin
      line_len += n;
    end
  endfunction

  function automatic void push_word(kind_e k, logic [7:0] b, int rep, int cnt, int len);
    split_word_t w;
    w.kind   = k;
    w.byte_v = b;
    w.rep    = rep[5:0];
    w.cnt    = cnt[7:0];
    w.len    = len[11:0];
    w.ovf    = ovf_flag;
    w.last   = 1'b0;
    char_words.push_back(w);
  endfunction

  function automatic void append_copies(logic [7:0] b, int n);
    if (n == 0) return;
    add_len(n);
    push_word(K_BYTE, b, n, 0, 0);
  endfunction

  function automatic void open_arg();
    in_arg = 1'b1;
    if (arg_total >= ARGS_CAP) begin
      arg_total = ARGS_CAP;
      ovf_flag  = 1'b1;
    end else begin
      arg_total++;
    end
  endfunction

  function automatic void close_arg();
    add_len(1);
    push_word(K_ARG_END, 8'h00, 0, 0, 0);
    in_arg = 1'b0;
  endfunction

  // Works out the result words of one character and queues them.
  function automatic void split_char(logic [7:0] c);
    int          n;
    bit          ws;
    split_word_t w;
    n  = slash_run;
    ws = (c == CH_SPACE) || (c == CH_TAB);
    char_words.delete();
    if (c == CH_EOL) begin
      if (in_arg) begin
        append_copies(CH_BSLASH, n);
        close_arg();
      end
      push_word(K_LINE_END, 8'h00, 0, arg_total, line_len);
      in_arg     = 1'b0;
      quoted     = 1'b0;
      quote_hold = 1'b0;
      slash_run  = 0;
      arg_total  = 0;
      line_len   = 0;
      ovf_flag   = 1'b0;
    end else if (quote_hold && c == CH_QUOTE) begin
      quote_hold = 1'b0;
      append_copies(CH_QUOTE, 1);
    end else begin
      quote_hold = 1'b0;
      if (in_arg || !ws) begin
        if (!in_arg) open_arg();
        if (c == CH_BSLASH) begin
          if (slash_run >= RUN_CAP) begin
            slash_run = RUN_CAP;
            ovf_flag  = 1'b1;
          end else begin
            slash_run++;
          end
        end else if (c == CH_QUOTE) begin
          slash_run = 0;
          append_copies(CH_BSLASH, n >> 1);
          if (n % 2 == 0) begin
            if (quoted) begin
              quoted     = 1'b0;
              quote_hold = 1'b1;
            end else begin
              quoted = 1'b1;
            end
          end else begin
            append_copies(CH_QUOTE, 1);
          end
        end else begin
          slash_run = 0;
          append_copies(CH_BSLASH, n);
          if (ws && !quoted) close_arg();
          else append_copies(c, 1);
        end
      end
    end
    foreach (char_words[i]) begin
      w      = char_words[i];
      w.last = (i == char_words.size() - 1);
      expected_words.push_back(w);
    end
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 40) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  always @(posedge clk) begin
    split_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result word arrived with nothing expected");
      end else begin
        w = expected_words.pop_front();
        if (out_tuser !== w.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", out_tuser, w.kind));
        if (out_tdata[7:0] !== w.byte_v)
          report_mismatch($sformatf("byte %h, expected %h", out_tdata[7:0], w.byte_v));
        if (out_tdata[13:8] !== w.rep)
          report_mismatch($sformatf("repeat %0d, expected %0d", out_tdata[13:8], w.rep));
        if (out_tdata[21:14] !== w.cnt)
          report_mismatch($sformatf("arg count %0d, expected %0d", out_tdata[21:14], w.cnt));
        if (out_tdata[33:22] !== w.len)
          report_mismatch($sformatf("length %0d, expected %0d", out_tdata[33:22], w.len));
        if (out_tdata[34] !== w.ovf)
          report_mismatch($sformatf("overflow %b, expected %b", out_tdata[34], w.ovf));
        if (out_tdata[OUT_DW-1:35] !== '0)
          report_mismatch($sformatf("padding bits %h not zero", out_tdata[OUT_DW-1:35]));
        if (out_tlast !== w.last)
          report_mismatch($sformatf("last %b, expected %b", out_tlast, w.last));
      end
    end
  end

  // The receiver idles in short bursts and holds off for a long stretch on request.
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        while (hold_cycles > 0) begin
          @(posedge clk);
          hold_cycles--;
        end
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_char(input logic [7:0] c);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    split_char(c);
    chars_sent++;
  endtask

  task automatic send_line(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(CH_EOL);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_random_line(input int max_len);
    int n_tok;
    n_tok = $urandom_range(1, max_len);
    for (int i = 0; i < n_tok; i++) begin
      case ($urandom_range(0, 9))
        0, 1: send_char(8'($urandom_range(1, 255)));
        2, 3: send_char(8'($urandom_range(8'h61, 8'h7A)));
        4: send_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        5: send_char(CH_QUOTE);
        6: begin
          repeat ($urandom_range(1, 5)) send_char(CH_BSLASH);
          send_char($urandom_range(0, 1) ? CH_QUOTE : 8'h6B);
        end
        7: begin
          send_char(CH_QUOTE);
          send_char(CH_QUOTE);
        end
        8: send_char(CH_BSLASH);
        default: send_char(8'($urandom_range(0, 255)));
      endcase
    end
    send_char(CH_EOL);
  endtask

  task automatic test_directed();
    send_line("a\377\t\001 ");
    send_line("\"x \"\"y");
    send_line("\\\\\"\\\\\\\"\\c");
    send_line("\"a\"b\\");
    send_line("");
    drain();
  endtask

  task automatic test_run_limit();
    send_char(8'h78);
    repeat (66) send_char(CH_BSLASH);
    send_char(CH_QUOTE);
    send_char(CH_EOL);
    repeat (70) send_char(CH_BSLASH);
    send_char(8'h79);
    send_char(CH_EOL);
    drain();
  endtask

  task automatic test_count_limit();
    repeat (258) begin
      send_char(8'h61);
      send_char(CH_SPACE);
    end
    send_char(CH_EOL);
    drain();
  endtask

  task automatic test_length_limit();
    repeat (70) begin
      repeat (60) send_char(8'h6B);
      send_char(CH_TAB);
    end
    send_char(CH_EOL);
    drain();
  endtask

  task automatic test_output_stall();
    hold_cycles = 120;
    repeat (4) send_random_line(15);
    drain();
  endtask

  task automatic test_random();
    int target;
    target = chars_sent + 450;
    while (chars_sent < target) begin
      if (target - chars_sent < 100) idle_on = 1'b0;
      send_random_line(14);
    end
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_run_limit();
    test_count_limit();
    test_length_limit();
    test_output_stall();
    test_random();
    repeat (10) @(posedge clk);
    if (err_count == 0 && expected_words.size() == 0) begin
      $display("command_line_argument_splitter test passed");
    end else begin
      $display("command_line_argument_splitter test failed");
    end
    $finish;
  end

endmodule
